@@ rtl/core/sdl_pkg.sv @@
// Shared types, constants and the sine table builder for the speed limit unit.
package sdl_pkg;

   localparam int unsigned DIST_W   = 16;
   localparam int unsigned PITCH_W  = 12;
   localparam int unsigned CSR_W    = 10;
   localparam int unsigned SPEED_W  = 17;
   localparam int unsigned X_W      = 27;
   localparam int unsigned Y_W      = 62;
   localparam int unsigned RES_W    = 63;
   localparam int unsigned ROOT_W   = 31;
   localparam int unsigned CELLS    = 31;
   localparam int unsigned CELL_IDX_W = 5;
   localparam int unsigned SIN_W    = 10;
   localparam int unsigned ANG_W    = 11;
   localparam int unsigned SIN_DEPTH = 1572;

   localparam logic [1:0] CSR_REACTION = 2'd0;
   localparam logic [1:0] CSR_FRICTION = 2'd1;

   localparam logic [CSR_W-1:0] REACTION_RESET = 10'd400;
   localparam logic [CSR_W-1:0] FRICTION_RESET = 10'd250;

   localparam logic [SPEED_W-1:0] SPEED_FLOOR = 17'd100;
   localparam logic [SPEED_W-1:0] SPEED_CEIL  = 17'd100000;

   localparam logic [11:0] HALF_PI_MRAD = 12'd1571;
   localparam logic [11:0] PI_MRAD      = 12'd3142;

   // 196 * 10^8 = 76562500 * 2^8
   localparam logic [26:0] DIST_SCALE = 27'd76562500;
   // ceil(2^44 / 10000), exact floor division for 31-bit dividends
   localparam logic [30:0] RECIP_10K = 31'd1759218605;
   localparam int unsigned RECIP_SHIFT = 44;

   typedef logic [SIN_W-1:0] sdl_sin_rom_type [0:SIN_DEPTH-1];

   typedef struct packed {
      logic             vld;
      logic [Y_W-1:0]   rem;
      logic [RES_W-1:0] res;
      logic [X_W-1:0]   x;
      logic             nodec;
   } sdl_root_type;

   function automatic logic [SIN_W-1:0] sdl_sin_milli(input longint unsigned m);
      longint unsigned x2;
      longint unsigned t;
      longint unsigned p;
      longint unsigned q;
      begin
         q  = 64'd1 << 28;
         x2 = ((m * m) << 28) / 64'd1000000;
         t  = q;
         p  = ((x2 * t) >> 28) / 64'd72;
         t  = (p >= q) ? 64'd0 : q - p;
         p  = ((x2 * t) >> 28) / 64'd42;
         t  = (p >= q) ? 64'd0 : q - p;
         p  = ((x2 * t) >> 28) / 64'd20;
         t  = (p >= q) ? 64'd0 : q - p;
         p  = ((x2 * t) >> 28) / 64'd6;
         t  = (p >= q) ? 64'd0 : q - p;
         return SIN_W'((m * t + (64'd1 << 27)) >> 28);
      end
   endfunction

   function automatic sdl_sin_rom_type sdl_build_sin();
      sdl_sin_rom_type rom;
      begin
         for (int i = 0; i < SIN_DEPTH; i++) begin
            rom[i] = sdl_sin_milli(longint'(i));
         end
         return rom;
      end
   endfunction

endpackage

@@ rtl/core/stopping_distance_speed_limit_unit.sv @@
// Top level of the stopping-distance speed limit unit.
// Takes one transfer per cycle when the result side does not stall, and passes each
// through six front stages (sine table read, deceleration,
// two multiply stages, squaring, radicand sum), a chain of 31 square root cells
// that each settle one root bit, one reciprocal-multiply stage for the divide by
// 10000 and the output register. A stall on the result side holds the whole
// pipeline. There is no clearing pass after reset.
module stopping_distance_speed_limit_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [sdl_pkg::DIST_W-1:0]         req_distance_cm,
   input  logic signed [sdl_pkg::PITCH_W-1:0] req_pitch_mrad,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [sdl_pkg::SPEED_W-1:0]        rsp_speed_limit_mm_s,
   output logic                               rsp_at_floor,
   input  logic                               csr_we,
   input  logic [1:0]                         csr_idx,
   input  logic [sdl_pkg::CSR_W-1:0]          csr_wdata
);
   import sdl_pkg::*;

   logic              en;
   logic [CSR_W-1:0]  reaction_ff;
   logic [CSR_W-1:0]  friction_ff;
   sdl_root_type      chain [0:CELLS];

   logic [ROOT_W-1:0] root;
   logic [ROOT_W-1:0] diff;
   logic [61:0]       prod_ff;
   logic              nd_ff;
   logic              dv_ff;
   logic [17:0]       quot;
   logic [SPEED_W-1:0] speed_in;
   logic              floor_in;
   logic [SPEED_W-1:0] speed_ff;
   logic              floor_ff;
   logic              out_vld_ff;

   assign en        = !out_vld_ff || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         reaction_ff <= REACTION_RESET;
         friction_ff <= FRICTION_RESET;
      end else if (csr_we) begin
         case (csr_idx)
            CSR_REACTION: reaction_ff <= csr_wdata;
            CSR_FRICTION: friction_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   sdl_front u_front (
      .clock            (clock),
      .reset            (reset),
      .en               (en),
      .in_vld           (req_valid && req_ready),
      .distance_cm      (req_distance_cm),
      .pitch_mrad       (req_pitch_mrad),
      .reaction_time_ms (reaction_ff),
      .friction_milli   (friction_ff),
      .root_o           (chain[0])
   );

   for (genvar g = 0; g < CELLS; g++) begin : g_cell
      sdl_root_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .en       (en),
         .cell_idx (CELL_IDX_W'(CELLS - 1 - g)),
         .root_i   (chain[g]),
         .root_o   (chain[g+1])
      );
   end

   always_comb begin
      root = chain[CELLS].res[ROOT_W-1:0];
      diff = (root > ROOT_W'(chain[CELLS].x)) ? (root - ROOT_W'(chain[CELLS].x)) : '0;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= diff * RECIP_10K;
         nd_ff   <= chain[CELLS].nodec;
      end
   end

   always_comb begin
      quot     = prod_ff[61:RECIP_SHIFT];
      speed_in = quot[SPEED_W-1:0];
      floor_in = 1'b0;
      if (nd_ff || quot < 18'(SPEED_FLOOR)) begin
         speed_in = SPEED_FLOOR;
         floor_in = 1'b1;
      end else if (quot > 18'(SPEED_CEIL)) begin
         speed_in = SPEED_CEIL;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         speed_ff <= speed_in;
         floor_ff <= floor_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff      <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (en) begin
         dv_ff      <= chain[CELLS].vld;
         out_vld_ff <= dv_ff;
      end
   end

   assign rsp_valid            = out_vld_ff;
   assign rsp_speed_limit_mm_s = speed_ff;
   assign rsp_at_floor         = floor_ff;

endmodule

@@ rtl/core/sdl_front.sv @@
// Front pipeline: sine lookup, deceleration and the radicand of the speed equation.
module sdl_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             en,
   input  logic                             in_vld,
   input  logic [sdl_pkg::DIST_W-1:0]       distance_cm,
   input  logic signed [sdl_pkg::PITCH_W-1:0] pitch_mrad,
   input  logic [sdl_pkg::CSR_W-1:0]        reaction_time_ms,
   input  logic [sdl_pkg::CSR_W-1:0]        friction_milli,
   output sdl_pkg::sdl_root_type            root_o
);
   import sdl_pkg::*;

   localparam sdl_sin_rom_type SIN_ROM = sdl_build_sin();

   logic [11:0]      mag;
   logic [11:0]      fold;
   logic [ANG_W-1:0] addr;

   logic [SIN_W-1:0]  sin_ff;
   logic [DIST_W-1:0] d1_ff;
   logic [CSR_W-1:0]  s_in;
   logic [CSR_W-1:0]  s_ff;
   logic [DIST_W-1:0] d2_ff;
   logic              nd2_ff;
   logic              nd_in;
   logic [19:0]       sr_ff;
   logic [25:0]       p_ff;
   logic              nd3_ff;
   logic [X_W-1:0]    x4_ff;
   logic [52:0]       pm4_ff;
   logic              nd4_ff;
   logic [53:0]       xx5_ff;
   logic [X_W-1:0]    x5_ff;
   logic [52:0]       pm5_ff;
   logic              nd5_ff;
   logic [Y_W-1:0]    y_in;
   logic [5:1]        vld_ff;
   sdl_root_type      root_ff;

   always_comb begin
      // uphill counts as level; the most negative code is already its own magnitude
      mag  = pitch_mrad[PITCH_W-1] ? (12'h000 - pitch_mrad) : 12'h000;
      fold = (mag > HALF_PI_MRAD) ? (PI_MRAD - mag) : mag;
      addr = fold[ANG_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sin_ff <= SIN_ROM[addr];
         d1_ff  <= distance_cm;
      end
   end

   always_comb begin
      nd_in = (friction_milli <= sin_ff);
      s_in  = friction_milli - sin_ff;
   end

   assign y_in = Y_W'(xx5_ff) + {1'b0, pm5_ff, 8'h00};

   always_ff @(posedge clock) begin
      if (en) begin
         s_ff   <= s_in;
         d2_ff  <= d1_ff;
         nd2_ff <= nd_in;

         sr_ff  <= s_ff * reaction_time_ms;
         p_ff   <= s_ff * d2_ff;
         nd3_ff <= nd2_ff;

         x4_ff  <= X_W'(sr_ff) * X_W'(98);
         pm4_ff <= p_ff * DIST_SCALE;
         nd4_ff <= nd3_ff;

         xx5_ff <= x4_ff * x4_ff;
         x5_ff  <= x4_ff;
         pm5_ff <= pm4_ff;
         nd5_ff <= nd4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff      <= '0;
         root_ff.vld <= 1'b0;
      end else if (en) begin
         vld_ff        <= {vld_ff[4:1], in_vld};
         root_ff.vld   <= vld_ff[5];
         root_ff.rem   <= y_in;
         root_ff.res   <= '0;
         root_ff.x     <= x5_ff;
         root_ff.nodec <= nd5_ff;
      end
   end

   assign root_o = root_ff;

endmodule

@@ rtl/core/sdl_root_cell.sv @@
// One cell of the square root chain: resolves one result bit per cycle while en is high.
module sdl_root_cell (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic [sdl_pkg::CELL_IDX_W-1:0]  cell_idx,
   input  sdl_pkg::sdl_root_type           root_i,
   output sdl_pkg::sdl_root_type           root_o
);
   import sdl_pkg::*;

   logic [RES_W-1:0] bitv;
   logic [RES_W-1:0] trial;
   sdl_root_type     root_in;
   sdl_root_type     root_ff;

   always_comb begin
      bitv    = RES_W'(1) << {cell_idx, 1'b0};
      trial   = root_i.res + bitv;
      root_in = root_i;
      if (RES_W'(root_i.rem) >= trial) begin
         root_in.rem = root_i.rem - trial[Y_W-1:0];
         root_in.res = (root_i.res >> 1) + bitv;
      end else begin
         root_in.res = root_i.res >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_ff.vld <= 1'b0;
      end else if (en) begin
         root_ff <= root_in;
      end
   end

   assign root_o = root_ff;

endmodule

@@ rtl/core/sdl_checker.sv @@
// Port-level checks for the speed limit unit, bound to the top level.
module sdl_assertions (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [sdl_pkg::SPEED_W-1:0]        rsp_speed_limit_mm_s,
   input logic                               rsp_at_floor
);
   import sdl_pkg::*;

   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_speed_limit_mm_s >= SPEED_FLOOR &&
                     rsp_speed_limit_mm_s <= SPEED_CEIL))
      else $error("speed out of range");

   a_floor: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_at_floor) |-> rsp_speed_limit_mm_s == SPEED_FLOOR)
      else $error("floor flag with speed above floor");

   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("input stalled without a held result");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_speed_limit_mm_s) &&
                                     $stable(rsp_at_floor)))
      else $error("held result changed");

endmodule

bind stopping_distance_speed_limit_unit sdl_assertions u_sdl_assertions (.*);
